@@ sv/qau_pkg.sv @@
// shared constants, types and operation codes of the quaternion arithmetic unit
package qau_pkg;

  localparam int COMP_WIDTH = 16;
  localparam int FRAC_BITS  = 14;

  localparam int CW  = COMP_WIDTH;
  localparam int FB  = FRAC_BITS;
  localparam int MW  = CW + 1;        // magnitude width
  localparam int SW  = 2 * CW + 1;    // sum of squares width
  localparam int PW  = 2 * CW;        // product width
  localparam int HW  = 2 * CW + 2;    // four-term sum width
  localparam int QW  = CW + 1;        // quotient bits kept by the divider

  typedef logic signed [CW-1:0] comp_t;
  typedef comp_t [3:0] quat_t;        // index 0 x, 1 y, 2 z, 3 w
  typedef logic [2:0] func_t;

  localparam func_t FUNC_PROD = 3'd0;
  localparam func_t FUNC_VEC  = 3'd1;
  localparam func_t FUNC_CONJ = 3'd2;
  localparam func_t FUNC_LEN  = 3'd3;
  localparam func_t FUNC_NORM = 3'd4;

  localparam comp_t CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam comp_t CMIN = {1'b1, {(CW-1){1'b0}}};

  // what travels beside the length and divide pipes
  typedef struct packed {
    func_t func;
    quat_t a;
    quat_t q;     // result for everything except normalize
    logic  sat;
  } meta_t;

endpackage

@@ sv/qau_ifs.sv @@
// valid/ready channel interfaces for input and result words
interface qau_in_if;
  logic             valid;
  logic             ready;
  qau_pkg::func_t   func;
  qau_pkg::comp_t   a_x;
  qau_pkg::comp_t   a_y;
  qau_pkg::comp_t   a_z;
  qau_pkg::comp_t   a_w;
  qau_pkg::comp_t   b_x;
  qau_pkg::comp_t   b_y;
  qau_pkg::comp_t   b_z;
  qau_pkg::comp_t   b_w;
  modport source (output valid, func, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                  input ready);
  modport sink (input valid, func, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                output ready);
endinterface

interface qau_out_if;
  logic                       valid;
  logic                       ready;
  qau_pkg::comp_t             q_x;
  qau_pkg::comp_t             q_y;
  qau_pkg::comp_t             q_z;
  qau_pkg::comp_t             q_w;
  logic [qau_pkg::MW-1:0]     magnitude;
  logic                       zero_length;
  logic                       saturated;
  modport source (output valid, q_x, q_y, q_z, q_w, magnitude, zero_length, saturated,
                  input ready);
  modport sink (input valid, q_x, q_y, q_z, q_w, magnitude, zero_length, saturated,
                output ready);
endinterface

@@ sv/qau_front.sv @@
// front pipe: products, four-term sums, rounding, clipping and conjugate
module qau_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_vld,
  input  qau_pkg::func_t          in_func,
  input  qau_pkg::quat_t          in_a,
  input  qau_pkg::quat_t          in_b,
  output logic                    out_vld,
  output qau_pkg::meta_t          out_meta,
  output logic [qau_pkg::SW-1:0]  out_sumsq
);

  localparam logic signed [qau_pkg::HW-1:0] RND = qau_pkg::HW'(2 ** (qau_pkg::FB - 1));

  // stage a: products
  logic signed [qau_pkg::PW-1:0] p_nxt [4][4];
  logic signed [qau_pkg::PW-1:0] p_r   [4][4];
  logic signed [qau_pkg::PW-1:0] sq_nxt [4];
  logic signed [qau_pkg::PW-1:0] sq_r   [4];
  qau_pkg::quat_t                b_eff;
  qau_pkg::func_t                func_a_r;
  qau_pkg::quat_t                a_a_r;
  logic                          vld_a_r;

  // stage b: sums
  logic signed [qau_pkg::HW-1:0] h_nxt [4];
  logic signed [qau_pkg::HW-1:0] h_r   [4];
  logic [qau_pkg::SW-1:0]        sumsq_nxt;
  logic [qau_pkg::SW-1:0]        sumsq_b_r;
  qau_pkg::func_t                func_b_r;
  qau_pkg::quat_t                a_b_r;
  logic                          vld_b_r;

  // stage c: round, clip, select
  qau_pkg::meta_t                meta_nxt;
  qau_pkg::meta_t                meta_c_r;
  logic [qau_pkg::SW-1:0]        sumsq_c_r;
  logic                          vld_c_r;
  qau_pkg::quat_t                hq;
  qau_pkg::quat_t                cq;
  logic [3:0]                    hs;
  logic [3:0]                    cs;
  logic signed [qau_pkg::HW-1:0] hr;
  logic signed [qau_pkg::CW:0]   na;

  always_comb begin
    b_eff = in_b;
    if (in_func == qau_pkg::FUNC_VEC) begin
      b_eff[3] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p_nxt[i][j] = qau_pkg::PW'($signed(in_a[i])) * qau_pkg::PW'($signed(b_eff[j]));
      end
      sq_nxt[i] = qau_pkg::PW'($signed(in_a[i])) * qau_pkg::PW'($signed(in_a[i]));
    end
  end

  always_comb begin
    h_nxt[0] = qau_pkg::HW'(p_r[0][3]) + qau_pkg::HW'(p_r[3][0])
             + qau_pkg::HW'(p_r[1][2]) - qau_pkg::HW'(p_r[2][1]);
    h_nxt[1] = qau_pkg::HW'(p_r[1][3]) + qau_pkg::HW'(p_r[3][1])
             + qau_pkg::HW'(p_r[2][0]) - qau_pkg::HW'(p_r[0][2]);
    h_nxt[2] = qau_pkg::HW'(p_r[2][3]) + qau_pkg::HW'(p_r[3][2])
             + qau_pkg::HW'(p_r[0][1]) - qau_pkg::HW'(p_r[1][0]);
    h_nxt[3] = qau_pkg::HW'(p_r[3][3]) - qau_pkg::HW'(p_r[0][0])
             - qau_pkg::HW'(p_r[1][1]) - qau_pkg::HW'(p_r[2][2]);
    sumsq_nxt = qau_pkg::SW'(sq_r[0]) + qau_pkg::SW'(sq_r[1])
              + qau_pkg::SW'(sq_r[2]) + qau_pkg::SW'(sq_r[3]);
  end

  always_comb begin
    hr = '0;
    na = '0;
    for (int i = 0; i < 4; i++) begin
      // round half up, then clip
      hr = (h_r[i] + RND) >>> qau_pkg::FB;
      hs[i] = 1'b0;
      if (hr > qau_pkg::HW'(qau_pkg::CMAX)) begin
        hq[i] = qau_pkg::CMAX;
        hs[i] = 1'b1;
      end else if (hr < qau_pkg::HW'(qau_pkg::CMIN)) begin
        hq[i] = qau_pkg::CMIN;
        hs[i] = 1'b1;
      end else begin
        hq[i] = qau_pkg::CW'(hr);
      end
      // negation only overflows at the most negative value
      na = -($signed((qau_pkg::CW+1)'($signed(a_b_r[i]))));
      cs[i] = 1'b0;
      if (i == 3) begin
        cq[i] = a_b_r[i];
      end else if (na > (qau_pkg::CW+1)'(qau_pkg::CMAX)) begin
        cq[i] = qau_pkg::CMAX;
        cs[i] = 1'b1;
      end else begin
        cq[i] = qau_pkg::CW'(na);
      end
    end
    meta_nxt.func = func_b_r;
    meta_nxt.a    = a_b_r;
    case (func_b_r)
      qau_pkg::FUNC_PROD, qau_pkg::FUNC_VEC: begin
        meta_nxt.q   = hq;
        meta_nxt.sat = |hs;
      end
      qau_pkg::FUNC_CONJ: begin
        meta_nxt.q   = cq;
        meta_nxt.sat = |cs;
      end
      default: begin
        meta_nxt.q   = '0;
        meta_nxt.sat = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
    end else if (adv) begin
      vld_a_r <= in_vld;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r       <= p_nxt;
      sq_r      <= sq_nxt;
      func_a_r  <= in_func;
      a_a_r     <= in_a;
      h_r       <= h_nxt;
      sumsq_b_r <= sumsq_nxt;
      func_b_r  <= func_a_r;
      a_b_r     <= a_a_r;
      meta_c_r  <= meta_nxt;
      sumsq_c_r <= sumsq_b_r;
    end
  end

  assign out_vld   = vld_c_r;
  assign out_meta  = meta_c_r;
  assign out_sumsq = sumsq_c_r;

endmodule

@@ sv/qau_sqrt.sv @@
// pipelined rounded square root, one result bit per stage
module qau_sqrt (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_vld,
  input  qau_pkg::meta_t          in_meta,
  input  logic [qau_pkg::SW-1:0]  in_sumsq,
  output logic                    out_vld,
  output qau_pkg::meta_t          out_meta,
  output logic [qau_pkg::MW-1:0]  out_len
);

  localparam int RW  = qau_pkg::MW;
  localparam int RDW = 2 * RW;
  localparam int RMW = RW + 2;

  typedef struct packed {
    logic [RDW-1:0] rad;
    logic [RMW-1:0] rem;
    logic [RW-1:0]  root;
    qau_pkg::meta_t meta;
  } sstage_t;

  sstage_t st_nxt [RW];
  sstage_t st_r   [RW];
  logic    vld_r  [RW];
  sstage_t src;
  logic [RMW-1:0] rem2;
  logic [RMW-1:0] trial;

  qau_pkg::meta_t         meta_f_r;
  logic [RW-1:0]          len_f_r;
  logic                   vld_f_r;
  logic [RW-1:0]          len_nxt;

  always_comb begin
    src   = '0;
    rem2  = '0;
    trial = '0;
    for (int k = 0; k < RW; k++) begin
      if (k == 0) begin
        src.rad  = RDW'(in_sumsq);
        src.rem  = '0;
        src.root = '0;
        src.meta = in_meta;
      end else begin
        src = st_r[k-1];
      end
      rem2  = {src.rem[RMW-3:0], src.rad[RDW-1 -: 2]};
      trial = {src.root, 2'b01};
      st_nxt[k].meta = src.meta;
      st_nxt[k].rad  = src.rad << 2;
      if (rem2 >= trial) begin
        st_nxt[k].rem  = rem2 - trial;
        st_nxt[k].root = {src.root[RW-2:0], 1'b1};
      end else begin
        st_nxt[k].rem  = rem2;
        st_nxt[k].root = {src.root[RW-2:0], 1'b0};
      end
    end
  end

  // round to nearest: bump when remainder exceeds root
  always_comb begin
    if (st_r[RW-1].rem > RMW'(st_r[RW-1].root)) begin
      len_nxt = st_r[RW-1].root + 1'b1;
    end else begin
      len_nxt = st_r[RW-1].root;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < RW; k++) begin
        vld_r[k] <= 1'b0;
      end
      vld_f_r <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld;
      for (int k = 1; k < RW; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      vld_f_r <= vld_r[RW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < RW; k++) begin
        st_r[k] <= st_nxt[k];
      end
      meta_f_r <= st_r[RW-1].meta;
      len_f_r  <= len_nxt;
    end
  end

  assign out_vld  = vld_f_r;
  assign out_meta = meta_f_r;
  assign out_len  = len_f_r;

endmodule

@@ sv/qau_div.sv @@
// pipelined normalize divider: four rounded quotients, one bit per stage
module qau_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_vld,
  input  qau_pkg::meta_t          in_meta,
  input  logic [qau_pkg::MW-1:0]  in_len,
  output logic                    out_vld,
  output qau_pkg::meta_t          out_meta,
  output logic [qau_pkg::MW-1:0]  out_len,
  output qau_pkg::quat_t          out_q,
  output logic                    out_sat,
  output logic                    out_zl
);

  localparam int NW  = qau_pkg::CW + qau_pkg::FB + 1;
  localparam int QW  = qau_pkg::QW;
  localparam int MW  = qau_pkg::MW;
  localparam int DRW = MW + 1;
  localparam int HIW = NW - QW;
  localparam int CPW = HIW + MW;
  localparam logic [QW-1:0] NEG_LIM = QW'(1) << (qau_pkg::CW - 1);
  localparam logic [QW-1:0] POS_LIM = NEG_LIM - 1'b1;

  typedef struct packed {
    logic [3:0][DRW-1:0] rem;
    logic [3:0][QW-1:0]  low;
    logic [3:0][QW-1:0]  quo;
    logic [3:0]          neg;
    logic [3:0]          ovf;
    logic [MW-1:0]       len;
    qau_pkg::meta_t      meta;
  } dstage_t;

  dstage_t prep_nxt;
  dstage_t st_nxt [QW+1];
  dstage_t st_r   [QW+1];
  logic    vld_r  [QW+1];
  dstage_t src;
  logic [qau_pkg::CW-1:0] mag;
  logic [NW-1:0]          num;
  logic [DRW-1:0]         rem2;

  qau_pkg::quat_t  q_nxt;
  logic [3:0]      s_nxt;
  logic            zl_nxt;
  logic [QW-1:0]   quo;

  qau_pkg::quat_t  q_f_r;
  logic            sat_f_r;
  logic            zl_f_r;
  logic [MW-1:0]   len_f_r;
  qau_pkg::meta_t  meta_f_r;
  logic            vld_f_r;

  // prepare: numerator |c| * 2^FB + len/2, early overflow check on high part
  always_comb begin
    mag = '0;
    num = '0;
    prep_nxt.meta = in_meta;
    prep_nxt.len  = in_len;
    prep_nxt.quo  = '0;
    for (int i = 0; i < 4; i++) begin
      prep_nxt.neg[i] = in_meta.a[i][qau_pkg::CW-1];
      mag = prep_nxt.neg[i] ? qau_pkg::CW'(-in_meta.a[i]) : qau_pkg::CW'(in_meta.a[i]);
      num = (NW'(mag) << qau_pkg::FB) + NW'(in_len >> 1);
      prep_nxt.ovf[i] = {{MW{1'b0}}, num[NW-1:QW]} >= CPW'(in_len);
      prep_nxt.rem[i] = DRW'(num >> QW);
      prep_nxt.low[i] = num[QW-1:0];
    end
  end

  always_comb begin
    src  = '0;
    rem2 = '0;
    st_nxt[0] = prep_nxt;
    for (int k = 1; k <= QW; k++) begin
      src = st_r[k-1];
      st_nxt[k] = src;
      for (int i = 0; i < 4; i++) begin
        rem2 = {src.rem[i][DRW-2:0], src.low[i][QW-1]};
        st_nxt[k].low[i] = src.low[i] << 1;
        if (rem2 >= DRW'(src.len)) begin
          st_nxt[k].rem[i] = rem2 - DRW'(src.len);
          st_nxt[k].quo[i] = {src.quo[i][QW-2:0], 1'b1};
        end else begin
          st_nxt[k].rem[i] = rem2;
          st_nxt[k].quo[i] = {src.quo[i][QW-2:0], 1'b0};
        end
      end
    end
  end

  // sign, saturate, zero length
  always_comb begin
    quo    = '0;
    zl_nxt = (st_r[QW].len == '0);
    for (int i = 0; i < 4; i++) begin
      quo = st_r[QW].quo[i];
      s_nxt[i] = 1'b0;
      if (zl_nxt) begin
        q_nxt[i] = '0;
      end else if (st_r[QW].neg[i]) begin
        if (st_r[QW].ovf[i] || quo > NEG_LIM) begin
          q_nxt[i] = qau_pkg::CMIN;
          s_nxt[i] = 1'b1;
        end else begin
          q_nxt[i] = qau_pkg::CW'(QW'(0) - quo);
        end
      end else begin
        if (st_r[QW].ovf[i] || quo > POS_LIM) begin
          q_nxt[i] = qau_pkg::CMAX;
          s_nxt[i] = 1'b1;
        end else begin
          q_nxt[i] = qau_pkg::CW'(quo);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QW; k++) begin
        vld_r[k] <= 1'b0;
      end
      vld_f_r <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld;
      for (int k = 1; k <= QW; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      vld_f_r <= vld_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= QW; k++) begin
        st_r[k] <= st_nxt[k];
      end
      q_f_r    <= q_nxt;
      sat_f_r  <= |s_nxt;
      zl_f_r   <= zl_nxt;
      len_f_r  <= st_r[QW].len;
      meta_f_r <= st_r[QW].meta;
    end
  end

  assign out_vld  = vld_f_r;
  assign out_meta = meta_f_r;
  assign out_len  = len_f_r;
  assign out_q    = q_f_r;
  assign out_sat  = sat_f_r;
  assign out_zl   = zl_f_r;

endmodule

@@ sv/quaternion_arithmetic_unit.sv @@
// throughput: one word per cycle; every stage advances together unless the
//   output register holds a word that is not taken
// path: 3 front stages, 17 root stages + 1 rounding, 1 + 17 divide stages + 1, output
// reset: synchronous active-low rst_n clears all valid bits; the data registers are not reset
module quaternion_arithmetic_unit (
  input logic       clk,
  input logic       rst_n,
  qau_in_if.sink    in_if,
  qau_out_if.source out_if
);

  // whole pipe moves when the output register is empty or drained
  logic adv;

  qau_pkg::quat_t a_in;
  qau_pkg::quat_t b_in;

  logic                   fr_vld;
  qau_pkg::meta_t         fr_meta;
  logic [qau_pkg::SW-1:0] fr_sumsq;

  logic                   sq_vld;
  qau_pkg::meta_t         sq_meta;
  logic [qau_pkg::MW-1:0] sq_len;

  logic                   dv_vld;
  qau_pkg::meta_t         dv_meta;
  logic [qau_pkg::MW-1:0] dv_len;
  qau_pkg::quat_t         dv_q;
  logic                   dv_sat;
  logic                   dv_zl;

  // output register
  logic                   out_vld_r;
  qau_pkg::quat_t         q_r;
  qau_pkg::quat_t         q_nxt;
  logic [qau_pkg::MW-1:0] mag_r;
  logic                   zl_r;
  logic                   zl_nxt;
  logic                   sat_r;
  logic                   sat_nxt;

  assign adv         = !out_vld_r || out_if.ready;
  assign in_if.ready = adv;

  assign a_in = {in_if.a_w, in_if.a_z, in_if.a_y, in_if.a_x};
  assign b_in = {in_if.b_w, in_if.b_z, in_if.b_y, in_if.b_x};

  // products, sums, conjugate
  qau_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_vld    (in_if.valid),
    .in_func   (in_if.func),
    .in_a      (a_in),
    .in_b      (b_in),
    .out_vld   (fr_vld),
    .out_meta  (fr_meta),
    .out_sumsq (fr_sumsq)
  );

  // length of a
  qau_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (fr_vld),
    .in_meta  (fr_meta),
    .in_sumsq (fr_sumsq),
    .out_vld  (sq_vld),
    .out_meta (sq_meta),
    .out_len  (sq_len)
  );

  // normalize quotients
  qau_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (sq_vld),
    .in_meta  (sq_meta),
    .in_len   (sq_len),
    .out_vld  (dv_vld),
    .out_meta (dv_meta),
    .out_len  (dv_len),
    .out_q    (dv_q),
    .out_sat  (dv_sat),
    .out_zl   (dv_zl)
  );

  // normalize takes the divider result, the rest was settled up front
  always_comb begin
    if (dv_meta.func == qau_pkg::FUNC_NORM) begin
      q_nxt   = dv_q;
      sat_nxt = dv_sat;
      zl_nxt  = dv_zl;
    end else begin
      q_nxt   = dv_meta.q;
      sat_nxt = dv_meta.sat;
      zl_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_r   <= q_nxt;
      mag_r <= dv_len;
      zl_r  <= zl_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_if.valid       = out_vld_r;
  assign out_if.q_x         = q_r[0];
  assign out_if.q_y         = q_r[1];
  assign out_if.q_z         = q_r[2];
  assign out_if.q_w         = q_r[3];
  assign out_if.magnitude   = mag_r;
  assign out_if.zero_length = zl_r;
  assign out_if.saturated   = sat_r;

endmodule

@@ test/qau_checker.sv @@
// checker for the quaternion arithmetic unit: predicts each result word and compares it
module qau_checker (
  input  logic      clk,
  input  logic      rst_n,
  qau_in_if.sink    in_if,
  qau_out_if.sink   out_if,
  output int        fail_count,
  output int        pending_count,
  output logic      word_moved
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    qau_pkg::comp_t         q_x, q_y, q_z, q_w;
    logic [qau_pkg::MW-1:0] magnitude;
    logic                   zero_length;
    logic                   saturated;
  } result_t;

  result_t expected_results[$];

  // floor divide by 2^FB, returns remainder too
  function automatic longint floor_frac(longint p, output longint rem);
    longint q;
    q = p >>> qau_pkg::FB;
    rem = p - (q <<< qau_pkg::FB);
    return q;
  endfunction

  // exact four-term sum, rounded half up
  function automatic longint round_sum4(longint t0, longint t1, longint t2, longint t3);
    longint qs, rs, r;
    qs = floor_frac(t0, r); rs = r;
    qs += floor_frac(t1, r); rs += r;
    qs += floor_frac(t2, r); rs += r;
    qs += floor_frac(t3, r); rs += r;
    rs += longint'(1) <<< (qau_pkg::FB - 1);
    return qs + (rs >>> qau_pkg::FB);
  endfunction

  function automatic longint clip_comp(longint v, inout logic sat);
    if (v > longint'(qau_pkg::CMAX)) begin
      sat = 1'b1;
      return longint'(qau_pkg::CMAX);
    end
    if (v < longint'(qau_pkg::CMIN)) begin
      sat = 1'b1;
      return longint'(qau_pkg::CMIN);
    end
    return v;
  endfunction

  // nearest-rounded square root of the sum of squares
  function automatic longint quat_length(longint c[4]);
    longint unsigned s, r, bitv;
    longint unsigned acc;
    s = 0;
    for (int i = 0; i < 4; i++) s += longint'(c[i] * c[i]);
    acc = s;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > acc) bitv >>= 2;
    while (bitv != 0) begin
      if (acc >= r + bitv) begin
        acc -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    if (s - r * r > r) r += 1;
    return longint'(r);
  endfunction

  function automatic longint norm_div(longint c, longint len);
    longint m, q;
    m = (c < 0 ? -c : c) <<< qau_pkg::FB;
    q = (m + (len >>> 1)) / len;
    return c < 0 ? -q : q;
  endfunction

  function automatic result_t predict_result(qau_pkg::func_t f, longint a[4], longint b[4]);
    longint q[4];
    longint len, bw;
    logic sat, zl;
    result_t res;
    q = '{0, 0, 0, 0};
    sat = 1'b0;
    zl = 1'b0;
    len = quat_length(a);
    if (f == qau_pkg::FUNC_PROD || f == qau_pkg::FUNC_VEC) begin
      bw = (f == qau_pkg::FUNC_VEC) ? 0 : b[3];
      q[0] = round_sum4(a[0]*bw, a[3]*b[0], a[1]*b[2], -(a[2]*b[1]));
      q[1] = round_sum4(a[1]*bw, a[3]*b[1], a[2]*b[0], -(a[0]*b[2]));
      q[2] = round_sum4(a[2]*bw, a[3]*b[2], a[0]*b[1], -(a[1]*b[0]));
      q[3] = round_sum4(a[3]*bw, -(a[0]*b[0]), -(a[1]*b[1]), -(a[2]*b[2]));
    end else if (f == qau_pkg::FUNC_CONJ) begin
      q = '{-a[0], -a[1], -a[2], a[3]};
    end else if (f == qau_pkg::FUNC_NORM) begin
      if (len == 0) zl = 1'b1;
      else for (int i = 0; i < 4; i++) q[i] = norm_div(a[i], len);
    end
    for (int i = 0; i < 4; i++) q[i] = clip_comp(q[i], sat);
    res.q_x = qau_pkg::comp_t'(q[0]);
    res.q_y = qau_pkg::comp_t'(q[1]);
    res.q_z = qau_pkg::comp_t'(q[2]);
    res.q_w = qau_pkg::comp_t'(q[3]);
    res.magnitude = len[qau_pkg::MW-1:0];
    res.zero_length = zl;
    res.saturated = sat;
    return res;
  endfunction

  assign pending_count = expected_results.size();

  always @(posedge clk) begin
    result_t got, exp_res;
    longint a[4], b[4];
    logic moved;
    moved = 1'b0;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        a = '{in_if.a_x, in_if.a_y, in_if.a_z, in_if.a_w};
        b = '{in_if.b_x, in_if.b_y, in_if.b_z, in_if.b_w};
        expected_results.push_back(predict_result(in_if.func, a, b));
        moved = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        moved = 1'b1;
        got = '{out_if.q_x, out_if.q_y, out_if.q_z, out_if.q_w,
                out_if.magnitude, out_if.zero_length, out_if.saturated};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_res = expected_results.pop_front();
          if (got !== exp_res) begin
            $display("%0t: mismatch expected x=%0d y=%0d z=%0d w=%0d mag=%0d zl=%b sat=%b",
                     $time, exp_res.q_x, exp_res.q_y, exp_res.q_z, exp_res.q_w,
                     exp_res.magnitude, exp_res.zero_length, exp_res.saturated);
            $display("%0t:          actual   x=%0d y=%0d z=%0d w=%0d mag=%0d zl=%b sat=%b",
                     $time, got.q_x, got.q_y, got.q_z, got.q_w,
                     got.magnitude, got.zero_length, got.saturated);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    word_moved <= moved;
  end
endmodule

@@ test/tb.sv @@
// top of the quaternion arithmetic unit testbench: stimulus, stalls and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 41;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam qau_pkg::comp_t HI  = qau_pkg::CMAX;
  localparam qau_pkg::comp_t LO  = qau_pkg::CMIN;
  localparam qau_pkg::comp_t ZR  = 16'sd0;
  localparam qau_pkg::comp_t ONE = 16'sd16384;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending_count;
  logic word_moved;

  // idle percentages, changed per phase
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;

  qau_in_if  in_ch();
  qau_out_if out_ch();

  quaternion_arithmetic_unit dut (.clk(clk), .rst_n(rst_n), .in_if(in_ch), .out_if(out_ch));
  qau_checker chk (.clk(clk), .rst_n(rst_n), .in_if(in_ch), .out_if(out_ch),
                   .fail_count(fail_count), .pending_count(pending_count),
                   .word_moved(word_moved));

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: random stalls, or a long hold-off while the sender keeps pushing
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) out_ch.ready <= 1'b0;
      else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: cycles with no word moving on either side
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (word_moved || hold_off || !rst_n) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("quaternion_arithmetic_unit test failed");
        $finish;
      end
    end
  end

  function automatic qau_pkg::comp_t rand_comp();
    case ($urandom_range(9))
      0: return HI;
      1: return LO;
      2: return ZR;
      3: return ONE;
      4: return -ONE;
      5: return qau_pkg::comp_t'($urandom_range(15) - 8);
      6: return qau_pkg::comp_t'($urandom_range(8000) - 4000);
      default: return qau_pkg::comp_t'($urandom);
    endcase
  endfunction

  // offer one word and hold it until accepted; valid stays up for the next word
  task automatic send_word(qau_pkg::func_t f,
                           qau_pkg::comp_t ax, qau_pkg::comp_t ay,
                           qau_pkg::comp_t az, qau_pkg::comp_t aw,
                           qau_pkg::comp_t bx, qau_pkg::comp_t by,
                           qau_pkg::comp_t bz, qau_pkg::comp_t bw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= f;
    in_ch.a_x <= ax; in_ch.a_y <= ay; in_ch.a_z <= az; in_ch.a_w <= aw;
    in_ch.b_x <= bx; in_ch.b_y <= by; in_ch.b_z <= bz; in_ch.b_w <= bw;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(int count);
    qau_pkg::func_t f;
    for (int i = 0; i < count; i++) begin
      // unused codes only occasionally
      f = ($urandom_range(19) == 0) ? qau_pkg::func_t'($urandom_range(7, 5))
                                    : qau_pkg::func_t'($urandom_range(4));
      send_word(f, rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                rand_comp(), rand_comp(), rand_comp(), rand_comp());
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = qau_pkg::FUNC_PROD;
    {in_ch.a_x, in_ch.a_y, in_ch.a_z, in_ch.a_w} = '0;
    {in_ch.b_x, in_ch.b_y, in_ch.b_z, in_ch.b_w} = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, every operation and the special cases
    send_word(qau_pkg::FUNC_PROD, HI, HI, HI, HI, HI, HI, HI, HI);
    send_word(qau_pkg::FUNC_PROD, LO, LO, LO, LO, LO, LO, LO, LO);
    send_word(qau_pkg::FUNC_PROD, LO, HI, LO, HI, HI, LO, HI, LO);
    send_word(qau_pkg::FUNC_PROD, ZR, ZR, ZR, ONE, 16'sd1, -16'sd1, 16'sd2, ONE);
    send_word(qau_pkg::FUNC_PROD, 16'sd1, 16'sd1, 16'sd1, 16'sd1,
              -16'sd1, -16'sd1, -16'sd1, -16'sd1);
    send_word(qau_pkg::FUNC_VEC, HI, LO, HI, LO, LO, HI, LO, HI);
    send_word(qau_pkg::FUNC_VEC, ZR, ZR, ZR, ONE, 16'sd100, -16'sd200, 16'sd300, LO);
    send_word(qau_pkg::FUNC_CONJ, LO, LO, LO, LO, ZR, ZR, ZR, ZR);
    send_word(qau_pkg::FUNC_CONJ, HI, -16'sd1, 16'sd1, LO, ZR, ZR, ZR, ZR);
    send_word(qau_pkg::FUNC_LEN, LO, LO, LO, LO, HI, HI, HI, HI);
    send_word(qau_pkg::FUNC_LEN, HI, HI, HI, HI, ZR, ZR, ZR, ZR);
    send_word(qau_pkg::FUNC_LEN, ZR, ZR, ZR, ZR, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
    send_word(qau_pkg::FUNC_NORM, ZR, ZR, ZR, ZR, HI, HI, HI, HI);
    send_word(qau_pkg::FUNC_NORM, 16'sd1, ZR, ZR, ZR, ZR, ZR, ZR, ZR);
    send_word(qau_pkg::FUNC_NORM, -16'sd1, ZR, ZR, ZR, ZR, ZR, ZR, ZR);
    send_word(qau_pkg::FUNC_NORM, LO, ZR, ZR, ZR, ZR, ZR, ZR, ZR);
    send_word(qau_pkg::FUNC_NORM, 16'sd1, 16'sd1, 16'sd1, 16'sd1, ZR, ZR, ZR, ZR);
    send_word(qau_pkg::FUNC_NORM, LO, LO, LO, LO, ZR, ZR, ZR, ZR);
    send_word(qau_pkg::FUNC_NORM, 16'sd3, -16'sd4, ZR, ZR, ZR, ZR, ZR, ZR);
    send_word(3'd5, HI, 16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd6, 16'sd7);
    send_word(3'd6, LO, LO, ZR, ZR, LO, ZR, ZR, ZR);
    send_word(3'd7, ZR, ZR, ZR, ZR, HI, HI, HI, HI);

    // random phases with different idle patterns
    send_idle_pct = 0;  recv_stall_pct = 0;  send_random(290);
    send_idle_pct = 63; recv_stall_pct = 0;  send_random(270);
    send_idle_pct = 0;  recv_stall_pct = 63; send_random(270);
    send_idle_pct = 26; recv_stall_pct = 26; send_random(200);

    // long receiver hold-off so the pipe fills and stalls the input
    send_idle_pct = 0; recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(negedge clk);
        hold_off = 1'b0;
      end
      send_random(100);
    join
    in_ch.valid <= 1'b0;

    // drain, then let the pipe settle
    begin
      int waited;
      waited = 0;
      while (pending_count != 0 && waited < 20000) begin
        @(posedge clk);
        waited++;
      end
      repeat (2 * LATENCY) @(posedge clk);
      if (fail_count == 0 && pending_count == 0)
        $display("quaternion_arithmetic_unit test passed");
      else
        $display("quaternion_arithmetic_unit test failed");
      $finish;
    end
  end
endmodule
